FILE: sv/keyed_handle_cache_oldest_evict_defines.svh
// Assertion macros for the keyed handle cache.
// Used by the checker module; relies on clk and rst_n being in scope.
`ifndef KEYED_HANDLE_CACHE_OLDEST_EVICT_DEFINES_SVH
`define KEYED_HANDLE_CACHE_OLDEST_EVICT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KHCOE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed handle cache: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KHCOE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed handle cache: next-cycle check failed");

`endif

FILE: sv/khcoe_pkg.sv
// Shared types, widths and helpers for the keyed handle cache.
// No dependencies; every module imports this package.
package khcoe_pkg;

    localparam int NUM_ENTRIES_DEF = 8;
    localparam int KEY_BITS        = 32;
    localparam int HANDLE_BITS     = 16;
    localparam int AGE_BITS        = 32;

    typedef enum logic [1:0] {
        CMD_TAKE     = 2'd0,
        CMD_PUT      = 2'd1,
        CMD_DROP_KEY = 2'd2,
        CMD_DROP_ALL = 2'd3
    } command_t;

    typedef struct packed {
        command_t                command;
        logic [KEY_BITS-1:0]     owner_key;
        logic [HANDLE_BITS-1:0]  handle_in;
    } cmd_item_t;

    typedef struct packed {
        logic                    found;
        logic [HANDLE_BITS-1:0]  handle_out;
        logic                    dispose;
        logic                    last;
    } res_item_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]  handle;
        logic [KEY_BITS-1:0]     key;
        logic [AGE_BITS-1:0]     age;
    } entry_t;

    // Index width for a table of n entries; a single entry still gets one bit.
    function automatic int idx_width(input int n);
        idx_width = (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic res_item_t make_result(input logic found,
                                              input logic [HANDLE_BITS-1:0] handle,
                                              input logic dispose,
                                              input logic last);
        res_item_t r;
        r.found      = found;
        r.handle_out = handle;
        r.dispose    = dispose;
        r.last       = last;
        make_result  = r;
    endfunction

endpackage

FILE: sv/khcoe_mem.sv
// Entry store of the keyed handle cache: one synchronous memory with a
// registered read port, plus per-entry written flags so that reset empties it.
// Depends on khcoe_pkg.
module khcoe_mem #(
    parameter int NUM_ENTRIES = khcoe_pkg::NUM_ENTRIES_DEF,
    parameter int IDX_W       = khcoe_pkg::idx_width(NUM_ENTRIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output khcoe_pkg::entry_t   rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  khcoe_pkg::entry_t   wr_data
);
    import khcoe_pkg::*;

    entry_t                  mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0]  written_reg;
    entry_t                  rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // An entry never written since reset reads as all zero, i.e. empty.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= written_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/khcoe_ctrl.sv
// Command sequencer of the keyed handle cache: scans the entry store one
// entry per cycle unless a held result pauses it, writes entries back and
// drives the result register. Depends on khcoe_pkg.
module khcoe_ctrl #(
    parameter int NUM_ENTRIES = khcoe_pkg::NUM_ENTRIES_DEF,
    parameter int IDX_W       = khcoe_pkg::idx_width(NUM_ENTRIES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  khcoe_pkg::cmd_item_t cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output khcoe_pkg::res_item_t res,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    input  khcoe_pkg::entry_t    rd_data,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output khcoe_pkg::entry_t    wr_data
);
    import khcoe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUT,
        ST_FIN
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    state_t                  state_reg,       state_next;
    logic [IDX_W-1:0]        idx_reg,         idx_next;
    cmd_item_t               cmd_reg,         cmd_next;
    logic                    pend_valid_reg,  pend_valid_next;
    logic [HANDLE_BITS-1:0]  pend_handle_reg, pend_handle_next;
    logic [AGE_BITS-1:0]     best_age_reg,    best_age_next;
    logic [IDX_W-1:0]        target_reg,      target_next;
    logic [HANDLE_BITS-1:0]  tgt_handle_reg,  tgt_handle_next;
    logic [AGE_BITS-1:0]     age_reg,         age_next;
    logic                    res_valid_reg,   res_valid_next;
    res_item_t               res_reg,         res_next;

    logic out_free;
    logic occupied;
    logic key_eq;
    logic last_idx;
    logic drop_match;

    assign out_free   = !res_valid_reg || !res_stall;
    assign occupied   = rd_data.handle != '0;
    assign key_eq     = rd_data.key == cmd_reg.owner_key;
    assign last_idx   = idx_reg == LAST_IDX;
    assign drop_match = occupied && (cmd_reg.command == CMD_DROP_ALL || key_eq);

    assign cmd_stall = state_reg != ST_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cmd_next         = cmd_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        best_age_next    = best_age_reg;
        target_next      = target_reg;
        tgt_handle_next  = tgt_handle_reg;
        age_next         = age_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_next         = res_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next        = cmd;
                    idx_next        = '0;
                    rd_en           = 1'b1;
                    rd_addr         = '0;
                    pend_valid_next = 1'b0;
                    best_age_next   = '0;
                    target_next     = '0;
                    tgt_handle_next = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                case (cmd_reg.command)
                    CMD_TAKE:
                    begin
                        if (occupied && key_eq)
                        begin
                            // Hit: the entry keeps its key and age, only the
                            // handle is cleared.
                            if (out_free)
                            begin
                                res_valid_next = 1'b1;
                                res_next       = make_result(1'b1, rd_data.handle,
                                                             1'b0, 1'b1);
                                wr_en          = 1'b1;
                                wr_data        = rd_data;
                                wr_data.handle = '0;
                                state_next     = ST_IDLE;
                            end
                        end
                        else if (last_idx)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            rd_en    = 1'b1;
                            rd_addr  = idx_reg + 1'b1;
                        end
                    end

                    CMD_PUT:
                    begin
                        if (!occupied)
                        begin
                            target_next     = idx_reg;
                            tgt_handle_next = '0;
                            state_next      = ST_PUT;
                        end
                        else
                        begin
                            if (idx_reg == '0 || rd_data.age < best_age_reg)
                            begin
                                best_age_next   = rd_data.age;
                                target_next     = idx_reg;
                                tgt_handle_next = rd_data.handle;
                            end
                            if (last_idx)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                                rd_en    = 1'b1;
                                rd_addr  = idx_reg + 1'b1;
                            end
                        end
                    end

                    default:
                    begin
                        // One match is held back so that the final transfer of
                        // the run can carry the last flag.
                        if (!(drop_match && pend_valid_reg && !out_free))
                        begin
                            if (drop_match)
                            begin
                                if (pend_valid_reg)
                                begin
                                    res_valid_next = 1'b1;
                                    res_next       = make_result(1'b0, pend_handle_reg,
                                                                 1'b1, 1'b0);
                                end
                                pend_valid_next  = 1'b1;
                                pend_handle_next = rd_data.handle;
                                wr_en            = 1'b1;
                                wr_data          = '0;
                            end
                            if (last_idx)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                                rd_en    = 1'b1;
                                rd_addr  = idx_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end

            ST_PUT:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = target_reg;
                    wr_data.handle = cmd_reg.handle_in;
                    wr_data.key    = cmd_reg.owner_key;
                    wr_data.age    = age_reg + 1'b1;
                    age_next       = age_reg + 1'b1;
                    res_valid_next = 1'b1;
                    res_next       = make_result(1'b0, tgt_handle_reg,
                                                 tgt_handle_reg != '0, 1'b1);
                    state_next     = ST_IDLE;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = make_result(1'b0,
                                                 pend_valid_reg ? pend_handle_reg : '0,
                                                 pend_valid_reg, 1'b1);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            cmd_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            pend_handle_reg <= '0;
            best_age_reg    <= '0;
            target_reg      <= '0;
            tgt_handle_reg  <= '0;
            age_reg         <= '0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cmd_reg         <= cmd_next;
            pend_valid_reg  <= pend_valid_next;
            pend_handle_reg <= pend_handle_next;
            best_age_reg    <= best_age_next;
            target_reg      <= target_next;
            tgt_handle_reg  <= tgt_handle_next;
            age_reg         <= age_next;
            res_valid_reg   <= res_valid_next;
            res_reg         <= res_next;
        end
    end

endmodule

FILE: sv/keyed_handle_cache_oldest_evict.sv
// Keyed handle cache with oldest-entry replacement: top level.
// Uses khcoe_pkg, khcoe_mem and khcoe_ctrl.
//
// Commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd) and results
// leave on the res channel (res_valid, res_stall, res); a transfer happens
// when valid is high and stall is low. Each command yields one or more
// results, the final one flagged by res.last.
// The table lives in a memory read one entry per cycle while the scan runs.
// A command reads entry 0 in its transfer cycle and examines one entry per
// cycle after that; a take hit stops early, at the matching entry, and a put
// stops at the first empty entry, or else picks the oldest, and then writes
// the new entry. The next command is taken once the sequencer is idle, even
// while the last result still waits in the output register.
// When res_stall holds a result, a command that has a further result to give
// pauses its scan until the output register frees up.
// Reset empties the table at once through per-entry written flags, clears the
// age counter and leaves both channels idle.
module keyed_handle_cache_oldest_evict #(
    parameter int NUM_ENTRIES = khcoe_pkg::NUM_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  khcoe_pkg::cmd_item_t cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output khcoe_pkg::res_item_t res
);
    import khcoe_pkg::*;

    localparam int IDX_W = idx_width(NUM_ENTRIES);

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    khcoe_mem #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    khcoe_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

endmodule

FILE: sv/khcoe_checker.sv
// Port-level checks for the keyed handle cache, bound to the top level.
// Depends on khcoe_pkg and keyed_handle_cache_oldest_evict_defines.svh.
`include "keyed_handle_cache_oldest_evict_defines.svh"

module khcoe_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  khcoe_pkg::cmd_item_t cmd,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  khcoe_pkg::res_item_t res
);
    import khcoe_pkg::*;

    // A held result stays offered and unchanged.
    `KHCOE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

    // A take hit ends its command and never asks for disposal.
    `KHCOE_ASSERT_NOW(a_hit_alone, res_valid && res.found, !res.dispose && res.last)

    // A take hit returns a real handle.
    `KHCOE_ASSERT_NOW(a_hit_handle, res_valid && res.found, res.handle_out != '0)

    // A result that neither returns nor disposes is the lone empty result.
    `KHCOE_ASSERT_NOW(a_empty_result, res_valid && !res.found && !res.dispose,
                      res.handle_out == '0 && res.last)

    // The sequencer takes no command while a non-final result is waiting.
    `KHCOE_ASSERT_NOW(a_no_cmd_mid_run, res_valid && !res.last, cmd_stall)

endmodule

bind keyed_handle_cache_oldest_evict khcoe_checker u_checker (.*);
